### design/ssg_pkg.sv
// Shared types and constants for the stepper ramp step generator.
// No dependencies; imported by every other design file except ssg_if.
package ssg_pkg;

   typedef enum logic [3:0] {
      KIND_ALARM     = 4'd0,
      KIND_TICK      = 4'd1,
      KIND_SET_SPEED = 4'd2,
      KIND_START     = 4'd3,
      KIND_STOP      = 4'd4,
      KIND_HARD_STOP = 4'd5,
      KIND_SET_TGT   = 4'd6,
      KIND_CLR_TGT   = 4'd7,
      KIND_RST_POS   = 4'd8
   } kind_type;

   typedef enum logic [2:0] {
      CSR_DIR      = 3'd0,
      CSR_MIN_RUN  = 3'd1,
      CSR_IDLE_PER = 3'd2,
      CSR_MIN_PER  = 3'd3,
      CSR_CLK_HZ   = 3'd4
   } csr_idx_type;

   localparam logic [9:0]  RST_MIN_RUN  = 10'd1;
   localparam logic [23:0] RST_IDLE_PER = 24'd1000;
   localparam logic [15:0] RST_MIN_PER  = 16'd10;
   localparam logic [26:0] RST_CLK_HZ   = 27'd1000000;

   localparam logic [5:0] MUL_STEPS = 6'd32;
   localparam logic [5:0] DIV_STEPS = 6'd40;

   typedef struct packed {
      logic        dir_fwd;
      logic [9:0]  min_run;
      logic [23:0] idle_per;
      logic [15:0] min_per;
      logic [26:0] clk_hz;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RAMP,
      ST_MUL_WAIT,
      ST_STEP,
      ST_PERIOD,
      ST_PER_WAIT,
      ST_HALT,
      ST_UP,
      ST_UP_WAIT,
      ST_DN,
      ST_DN_WAIT,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic ready;
      logic exec;
      logic mul_go;
      logic step;
      logic per_go;
      logic per_store;
      logic per_idle;
      logic halt_chk;
      logic up_go;
      logic up_store;
      logic dn_go;
      logic dn_store;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic     req_valid;
      kind_type kind;
      logic     run;
      logic     dt_nz;
      logic     spd_nz;
      logic     up_nz;
      logic     dn_nz;
      logic     rate_nz;
      logic     per_ok;
      logic     arith_done;
      logic     rsp_free;
   } status_type;

endpackage

### design/ssg_if.sv
// Valid/ready channel interfaces for request and response items.
// Standalone; used by the datapath and the top level.
interface ssg_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [31:0] now_ms;
   logic [19:0] speed_target;
   logic [15:0] ramp_up_ms;
   logic [15:0] ramp_down_ms;
   logic signed [31:0] position_target;

   modport source (output valid, kind, now_ms, speed_target, ramp_up_ms, ramp_down_ms,
                   position_target, input ready);
   modport sink (input valid, kind, now_ms, speed_target, ramp_up_ms, ramp_down_ms,
                 position_target, output ready);
endinterface

interface ssg_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_level;
   logic signed [31:0] position;
   logic        moving;
   logic [31:0] speed_now;
   logic [23:0] alarm_period;
   logic        target_hit;
   logic        auto_halt;

   modport source (output valid, step_level, position, moving, speed_now, alarm_period,
                   target_hit, auto_halt, input ready);
   modport sink (input valid, step_level, position, moving, speed_now, alarm_period,
                 target_hit, auto_halt, output ready);
endinterface

### design/stepper_ramp_step_generator.sv
// Top level of the stepper ramp step generator: CSR bank and unit wiring.
// Depends on ssg_pkg, ssg_if, ssg_ctrl and ssg_datapath.
//
// Usage:
//  - req_chan carries one command item (alarm, ramp tick, set speed, start,
//    stop, hard stop, set/clear target, reset position). rsp_chan returns
//    exactly one result item per command with the state after that item.
//  - The APB port writes the five setup registers at 4*index; write only
//    while no item is in flight.
//  - Items are handled one at a time. A simple command passes through the
//    execute and output states. A ramp tick uses at most a 32-step serial
//    multiply for the speed step, then a 40-step serial divide for the
//    period. Set speed uses at most two 40-step divides for the rates, all
//    on one shared serial unit.
//  - The result sits in an output register; a new item is accepted while it
//    waits. If the receiver stalls, the next item finishes internally and
//    holds in its last phase until the output register frees.
//  - Synchronous reset puts registers at their defaults, the motor stopped
//    at position 0 and the alarm period at 1000 ticks.
module stepper_ramp_step_generator import ssg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ssg_req_if.sink     req_chan,
   ssg_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type     cfg_ff;
   status_type  status;
   cmd_type     cmd;
   csr_idx_type csr_idx;
   logic        csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = csr_idx_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   // config register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dir_fwd  <= 1'b1;
         cfg_ff.min_run  <= RST_MIN_RUN;
         cfg_ff.idle_per <= RST_IDLE_PER;
         cfg_ff.min_per  <= RST_MIN_PER;
         cfg_ff.clk_hz   <= RST_CLK_HZ;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DIR:      cfg_ff.dir_fwd  <= pwdata[0];
            CSR_MIN_RUN:  cfg_ff.min_run  <= pwdata[9:0];
            CSR_IDLE_PER: cfg_ff.idle_per <= pwdata[23:0];
            CSR_MIN_PER:  cfg_ff.min_per  <= pwdata[15:0];
            CSR_CLK_HZ:   cfg_ff.clk_hz   <= pwdata[26:0];
            default:      ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (csr_idx)
         CSR_DIR:      prdata = {31'd0, cfg_ff.dir_fwd};
         CSR_MIN_RUN:  prdata = {22'd0, cfg_ff.min_run};
         CSR_IDLE_PER: prdata = {8'd0, cfg_ff.idle_per};
         CSR_MIN_PER:  prdata = {16'd0, cfg_ff.min_per};
         CSR_CLK_HZ:   prdata = {5'd0, cfg_ff.clk_hz};
         default:      prdata = 32'd0;
      endcase
   end

   ssg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd)
   );

   ssg_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .cmd     (cmd),
      .status  (status),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

endmodule

### design/ssg_arith.sv
// Shared serial unit: shift-add multiply (40x32) and restoring divide (40/32).
// Depends on ssg_pkg.
module ssg_arith import ssg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        op_mul,
   input  logic [39:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [71:0] prod,
   output logic [39:0] quot
);

   logic [71:0] p_ff, p_in;
   logic [39:0] a_ff;
   logic [31:0] b_ff;
   logic        mul_ff;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [40:0] sum;
   logic [32:0] trial;
   logic        qbit;

   always_comb begin
      sum   = {1'b0, p_ff[71:32]} + (p_ff[0] ? {1'b0, a_ff} : 41'd0);
      trial = {p_ff[71:40], p_ff[39]};
      qbit  = (trial >= {1'b0, b_ff});
   end

   always_comb begin
      p_in    = p_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         p_in    = op_mul ? {40'd0, b} : {32'd0, a};
         busy_in = 1'b1;
         cnt_in  = op_mul ? MUL_STEPS : DIV_STEPS;
      end else if (busy_ff) begin
         if (mul_ff) begin
            p_in = {sum, p_ff[31:1]};
         end else begin
            p_in = {(qbit ? 32'(trial - {1'b0, b_ff}) : trial[31:0]), p_ff[38:0], qbit};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      cnt_ff <= cnt_in;
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         mul_ff <= op_mul;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = p_ff;
   assign quot = p_ff[39:0];

`ifndef SYNTHESIS
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("arith restarted while busy");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("arith done while busy");
   a_done_once : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("arith done held");
`endif

endmodule

### design/ssg_ctrl.sv
// Sequencing state machine: steps through one item's phases by command.
// Depends on ssg_pkg; drives ssg_datapath through cmd_type.
module ssg_ctrl import ssg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (status.req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (status.kind == KIND_TICK && status.run && status.dt_nz) begin
               state_in = ST_RAMP;
            end else if (status.kind == KIND_SET_SPEED && status.spd_nz) begin
               state_in = ST_UP;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RAMP:     state_in = status.rate_nz ? ST_MUL_WAIT : ST_STEP;
         ST_MUL_WAIT: if (status.arith_done) state_in = ST_STEP;
         ST_STEP:     state_in = ST_PERIOD;
         ST_PERIOD:   state_in = status.per_ok ? ST_PER_WAIT : ST_HALT;
         ST_PER_WAIT: if (status.arith_done) state_in = ST_HALT;
         ST_HALT:     state_in = ST_OUT;
         ST_UP:       state_in = status.up_nz ? ST_UP_WAIT : ST_DN;
         ST_UP_WAIT:  if (status.arith_done) state_in = ST_DN;
         ST_DN:       state_in = status.dn_nz ? ST_DN_WAIT : ST_OUT;
         ST_DN_WAIT:  if (status.arith_done) state_in = ST_OUT;
         ST_OUT:      if (status.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:     cmd.ready = 1'b1;
         ST_EXEC:     cmd.exec = 1'b1;
         ST_RAMP:     cmd.mul_go = status.rate_nz;
         ST_MUL_WAIT: ;
         ST_STEP:     cmd.step = 1'b1;
         ST_PERIOD: begin
            cmd.per_go   = status.per_ok;
            cmd.per_idle = !status.per_ok;
         end
         ST_PER_WAIT: cmd.per_store = status.arith_done;
         ST_HALT:     cmd.halt_chk = 1'b1;
         ST_UP: begin
            cmd.up_go    = status.up_nz;
            cmd.up_store = !status.up_nz;
         end
         ST_UP_WAIT:  cmd.up_store = status.arith_done;
         ST_DN: begin
            cmd.dn_go    = status.dn_nz;
            cmd.dn_store = !status.dn_nz;
         end
         ST_DN_WAIT:  cmd.dn_store = status.arith_done;
         ST_OUT:      cmd.out_load = status.rsp_free;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_out_ret : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && status.rsp_free) |=> state_ff == ST_IDLE)
      else $error("result load did not return to idle");
   a_exec_follows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && status.req_valid) |=> state_ff == ST_EXEC)
      else $error("accepted item not executed");
   a_wait_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RAMP && status.rate_nz) |=> state_ff == ST_MUL_WAIT)
      else $error("multiply not awaited");
`endif

endmodule

### design/ssg_datapath.sv
// Motion state registers, ramp/period arithmetic and the result register.
// Depends on ssg_pkg, ssg_if and ssg_arith.
module ssg_datapath import ssg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   ssg_req_if.sink    req_chan,
   ssg_rsp_if.source  rsp_chan
);

   // latched item
   kind_type    kind_ff;
   logic [31:0] now_ff;
   logic [19:0] spd_ff;
   logic [15:0] up_ff;
   logic [15:0] dn_ff;
   logic [31:0] ptgt_ff;

   // motion state
   logic        level_ff, level_in;
   logic        run_ff, run_in;
   logic [31:0] pos_ff, pos_in;
   logic        armed_ff, armed_in;
   logic [31:0] goal_pos_ff, goal_pos_in;
   logic        stop_pend_ff, stop_pend_in;
   logic [31:0] speed_ff, speed_in;
   logic [19:0] goal_ff, goal_in;
   logic [39:0] accel_ff, accel_in;
   logic [39:0] decel_ff, decel_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] dt_ff, dt_in;
   logic [23:0] period_ff, period_in;
   logic        hit_ff, hit_in;
   logic        halt_ff, halt_in;
   logic        rsp_valid_ff;

   logic        load;
   logic [23:0] idle_eff;
   logic [23:0] min_per_eff;
   logic [31:0] tq;
   logic [21:0] minq;
   logic signed [34:0] diff;
   logic [39:0] rate_sel;
   logic [31:0] mc;
   logic signed [34:0] mc_s;
   logic [31:0] ramp_speed;
   logic [23:0] per_sat;
   logic [31:0] step_pos;
   logic        reached;
   logic        slow;

   logic        ar_start, ar_mul, ar_done;
   logic [39:0] ar_a, ar_quot;
   logic [31:0] ar_b;
   logic [71:0] ar_prod;

   assign load = cmd.ready && req_chan.valid;
   assign req_chan.ready = cmd.ready;

   always_comb begin
      idle_eff    = (cfg.idle_per == 24'd0) ? 24'd1 : cfg.idle_per;
      min_per_eff = (cfg.min_per == 16'd0) ? 24'd1 : {8'd0, cfg.min_per};
      tq          = {goal_ff, 12'd0};
      minq        = {cfg.min_run, 12'd0};
      slow        = (speed_ff < {10'd0, minq}) || (speed_ff == 32'd0);
      diff        = $signed({3'd0, tq}) - $signed({3'd0, speed_ff});
      rate_sel    = (diff > 35'sd0) ? accel_ff : decel_ff;
      mc          = (ar_prod[71:40] != 32'd0) ? 32'hFFFF_FFFF : ar_prod[39:8];
      mc_s        = $signed({3'd0, mc});
      if (rate_sel == 40'd0) ramp_speed = tq;
      else if (diff > mc_s) ramp_speed = speed_ff + mc;
      else if (diff < -mc_s) ramp_speed = speed_ff - mc;
      else ramp_speed = tq;
      per_sat  = (ar_quot[39:24] != 16'd0) ? 24'hFF_FFFF : ar_quot[23:0];
      step_pos = cfg.dir_fwd ? (pos_ff + 32'd1) : (pos_ff - 32'd1);
      reached  = cfg.dir_fwd ? ($signed(step_pos) >= $signed(goal_pos_ff))
                             : ($signed(step_pos) <= $signed(goal_pos_ff));
   end

   // arithmetic unit operand select
   always_comb begin
      ar_start = cmd.mul_go || cmd.per_go || cmd.up_go || cmd.dn_go;
      ar_mul   = cmd.mul_go;
      ar_a     = rate_sel;
      ar_b     = dt_ff;
      if (cmd.per_go) begin
         ar_a = {2'd0, cfg.clk_hz, 11'd0};
         ar_b = speed_ff;
      end else if (cmd.up_go) begin
         ar_a = {spd_ff, 20'd0};
         ar_b = {16'd0, up_ff};
      end else if (cmd.dn_go) begin
         ar_a = {spd_ff, 20'd0};
         ar_b = {16'd0, dn_ff};
      end
   end

   ssg_arith u_arith (
      .clock (clock),
      .reset (reset),
      .start (ar_start),
      .op_mul(ar_mul),
      .a     (ar_a),
      .b     (ar_b),
      .done  (ar_done),
      .prod  (ar_prod),
      .quot  (ar_quot)
   );

   always_comb begin
      level_in     = level_ff;
      run_in       = run_ff;
      pos_in       = pos_ff;
      armed_in     = armed_ff;
      goal_pos_in  = goal_pos_ff;
      stop_pend_in = stop_pend_ff;
      speed_in     = speed_ff;
      goal_in      = goal_ff;
      accel_in     = accel_ff;
      decel_in     = decel_ff;
      last_in      = last_ff;
      dt_in        = dt_ff;
      period_in    = period_ff;
      hit_in       = hit_ff;
      halt_in      = halt_ff;

      if (load) begin
         hit_in  = 1'b0;
         halt_in = 1'b0;
      end

      if (cmd.exec) begin
         case (kind_ff)
            KIND_ALARM: begin
               if (!run_ff) begin
                  level_in = 1'b0;
               end else begin
                  level_in = !level_ff;
                  if (!level_ff) begin
                     pos_in = step_pos;
                     if (armed_ff && reached) begin
                        run_in       = 1'b0;
                        armed_in     = 1'b0;
                        stop_pend_in = 1'b1;
                        hit_in       = 1'b1;
                     end
                  end
               end
            end
            KIND_TICK: begin
               if (stop_pend_ff) begin
                  stop_pend_in = 1'b0;
                  speed_in     = 32'd0;
                  goal_in      = 20'd0;
               end
               dt_in   = now_ff - last_ff;
               last_in = now_ff;
            end
            KIND_SET_SPEED: goal_in = spd_ff;
            KIND_START: begin
               speed_in = 32'd0;
               run_in   = 1'b1;
            end
            KIND_STOP: goal_in = 20'd0;
            KIND_HARD_STOP: begin
               run_in    = 1'b0;
               speed_in  = 32'd0;
               goal_in   = 20'd0;
               period_in = idle_eff;
            end
            KIND_SET_TGT: begin
               goal_pos_in = ptgt_ff;
               armed_in    = 1'b1;
            end
            KIND_CLR_TGT: armed_in = 1'b0;
            KIND_RST_POS: pos_in = 32'd0;
            default: ;
         endcase
      end

      if (cmd.step) speed_in = ramp_speed;
      if (cmd.per_idle) period_in = idle_eff;
      if (cmd.per_store) period_in = (per_sat < min_per_eff) ? min_per_eff : per_sat;
      if (cmd.halt_chk && goal_ff == 20'd0 && speed_ff < {10'd0, minq}) begin
         run_in    = 1'b0;
         speed_in  = 32'd0;
         halt_in   = 1'b1;
         period_in = idle_eff;
      end
      if (cmd.up_store) accel_in = (up_ff != 16'd0) ? ar_quot : 40'd0;
      if (cmd.dn_store) decel_in = (dn_ff != 16'd0) ? ar_quot : 40'd0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_type'(req_chan.kind);
         now_ff  <= req_chan.now_ms;
         spd_ff  <= req_chan.speed_target;
         up_ff   <= req_chan.ramp_up_ms;
         dn_ff   <= req_chan.ramp_down_ms;
         ptgt_ff <= req_chan.position_target;
      end
      dt_ff <= dt_in;
      if (reset) begin
         level_ff     <= 1'b0;
         run_ff       <= 1'b0;
         pos_ff       <= 32'd0;
         armed_ff     <= 1'b0;
         goal_pos_ff  <= 32'd0;
         stop_pend_ff <= 1'b0;
         speed_ff     <= 32'd0;
         goal_ff      <= 20'd0;
         accel_ff     <= 40'd0;
         decel_ff     <= 40'd0;
         last_ff      <= 32'd0;
         period_ff    <= RST_IDLE_PER;
         hit_ff       <= 1'b0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         run_ff       <= run_in;
         pos_ff       <= pos_in;
         armed_ff     <= armed_in;
         goal_pos_ff  <= goal_pos_in;
         stop_pend_ff <= stop_pend_in;
         speed_ff     <= speed_in;
         goal_ff      <= goal_in;
         accel_ff     <= accel_in;
         decel_ff     <= decel_in;
         last_ff      <= last_in;
         period_ff    <= period_in;
         hit_ff       <= hit_in;
         halt_ff      <= halt_in;
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_chan.step_level   <= level_ff;
         rsp_chan.position     <= pos_ff;
         rsp_chan.moving       <= run_ff;
         rsp_chan.speed_now    <= speed_ff;
         rsp_chan.alarm_period <= period_ff;
         rsp_chan.target_hit   <= hit_ff;
         rsp_chan.auto_halt    <= halt_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   always_comb begin
      status.req_valid  = req_chan.valid;
      status.kind       = kind_ff;
      status.run        = run_ff;
      status.dt_nz      = (now_ff != last_ff);
      status.spd_nz     = (spd_ff != 20'd0);
      status.up_nz      = (up_ff != 16'd0);
      status.dn_nz      = (dn_ff != 16'd0);
      status.rate_nz    = (rate_sel != 40'd0);
      status.per_ok     = !slow;
      status.arith_done = ar_done;
      status.rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   end

`ifndef SYNTHESIS
   a_hit_stops : assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && hit_ff) |-> (!run_ff && stop_pend_ff))
      else $error("target hit without stop");
   a_halt_clean : assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && halt_ff) |-> (!run_ff && speed_ff == 32'd0))
      else $error("auto halt left motion");
   a_period_nz : assert property (@(posedge clock) disable iff (reset)
      period_ff != 24'd0) else $error("zero alarm period");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the stepper ramp step generator.
// Drives command items over ssg_req_if, checks every result against a
// built-in predictor; depends on ssg_pkg, ssg_if and the block's RTL.
module tb_top;
   import ssg_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ssg_req_if req_chan ();
   ssg_rsp_if rsp_chan ();

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   stepper_ramp_step_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   typedef struct {
      logic [3:0]         kind;
      logic [31:0]        now_ms;
      logic [19:0]        speed_target;
      logic [15:0]        ramp_up_ms;
      logic [15:0]        ramp_down_ms;
      logic signed [31:0] position_target;
   } cmd_item_t;

   typedef struct {
      logic               step_level;
      logic signed [31:0] position;
      logic               moving;
      logic [31:0]        speed_now;
      logic [23:0]        alarm_period;
      logic               target_hit;
      logic               auto_halt;
   } motor_state_t;

   typedef struct {
      cmd_item_t    item;
      logic         typed;
      motor_state_t want;
   } dir_row_t;

   // ---------------------------------------------------------------
   // Motor predictor: mirror of the block's state and setup registers
   // ---------------------------------------------------------------
   cfg_type     m_cfg;
   logic        m_level, m_run, m_armed, m_stop_pend;
   logic [31:0] m_pos, m_goal_pos, m_speed, m_last_ms;
   logic [19:0] m_goal_spd;
   logic [39:0] m_acc, m_dec;
   logic [23:0] m_period;

   motor_state_t motor_q[$];
   int           n_err = 0;

   function automatic logic [23:0] idle_ticks();
      return (m_cfg.idle_per == 0) ? 24'd1 : m_cfg.idle_per;
   endfunction

   // clock / (2 * speed) with speed in Q20.12, clamped to 24 bits and min period; idle below min run
   function automatic logic [23:0] period_for(logic [31:0] sq);
      logic [63:0] t;
      logic [63:0] floor_q;
      logic [23:0] mp;
      floor_q = {42'd0, m_cfg.min_run, 12'd0};
      mp = (m_cfg.min_per == 0) ? 24'd1 : {8'd0, m_cfg.min_per};
      if (sq == 0 || {32'd0, sq} < floor_q) return idle_ticks();
      t = {26'd0, m_cfg.clk_hz, 11'd0} / {32'd0, sq};
      if (t > 64'hFFFFFF) t = 64'hFFFFFF;
      if (t < {40'd0, mp}) t = {40'd0, mp};
      return t[23:0];
   endfunction

   // one slew-limited speed step over dt milliseconds
   function automatic logic [31:0] slew_speed(logic [31:0] dt);
      logic signed [63:0] goal_q, cur, diff, mc;
      logic [39:0]        rate;
      logic [127:0]       prod;
      goal_q = {32'd0, m_goal_spd, 12'd0};
      cur = {32'd0, m_speed};
      diff = goal_q - cur;
      rate = (diff > 0) ? m_acc : m_dec;
      if (rate == 0) return goal_q[31:0];
      prod = ({88'd0, rate} * {96'd0, dt}) >> 8;
      if (prod > 128'hFFFFFFFF) prod = 128'hFFFFFFFF;
      mc = {32'd0, prod[31:0]};
      if (diff > mc) return 32'(cur + mc);
      if (diff < -mc) return 32'(cur - mc);
      return goal_q[31:0];
   endfunction

   function automatic void motor_reset();
      m_cfg = '{dir_fwd: 1'b1, min_run: RST_MIN_RUN, idle_per: RST_IDLE_PER,
                min_per: RST_MIN_PER, clk_hz: RST_CLK_HZ};
      m_level = 0; m_run = 0; m_armed = 0; m_stop_pend = 0;
      m_pos = 0; m_goal_pos = 0; m_speed = 0; m_last_ms = 0;
      m_goal_spd = 0; m_acc = 0; m_dec = 0; m_period = RST_IDLE_PER;
   endfunction

   function automatic motor_state_t motor_step(cmd_item_t it);
      motor_state_t r;
      logic [31:0]  dt;
      logic         zero_goal, hit, halt;
      hit = 0;
      halt = 0;
      case (it.kind)
         KIND_ALARM: begin
            if (!m_run) m_level = 0;
            else begin
               m_level = ~m_level;
               if (m_level) begin
                  m_pos = m_cfg.dir_fwd ? m_pos + 1 : m_pos - 1;
                  if (m_armed && (m_cfg.dir_fwd ? $signed(m_pos) >= $signed(m_goal_pos)
                                                : $signed(m_pos) <= $signed(m_goal_pos))) begin
                     m_run = 0; m_armed = 0; m_stop_pend = 1; hit = 1;
                  end
               end
            end
         end
         KIND_TICK: begin
            // a reached target defers its speed clear to this tick
            if (m_stop_pend) begin
               m_stop_pend = 0; m_speed = 0; m_goal_spd = 0;
            end
            if (!m_run) m_last_ms = it.now_ms;
            else begin
               dt = it.now_ms - m_last_ms;
               m_last_ms = it.now_ms;
               if (dt != 0) begin
                  zero_goal = (m_goal_spd == 0);
                  m_speed = slew_speed(dt);
                  m_period = period_for(m_speed);
                  if (zero_goal && {32'd0, m_speed} < {42'd0, m_cfg.min_run, 12'd0}) begin
                     m_run = 0; m_speed = 0; halt = 1; m_period = idle_ticks();
                  end
               end
            end
         end
         KIND_SET_SPEED: begin
            m_goal_spd = it.speed_target;
            if (it.speed_target != 0) begin
               m_acc = (it.ramp_up_ms == 0) ? 40'd0 :
                       40'({it.speed_target, 20'd0} / {24'd0, it.ramp_up_ms});
               m_dec = (it.ramp_down_ms == 0) ? 40'd0 :
                       40'({it.speed_target, 20'd0} / {24'd0, it.ramp_down_ms});
            end
         end
         KIND_START: begin
            m_speed = 0; m_run = 1;
         end
         KIND_STOP: m_goal_spd = 0;
         KIND_HARD_STOP: begin
            m_run = 0; m_speed = 0; m_goal_spd = 0; m_period = idle_ticks();
         end
         KIND_SET_TGT: begin
            m_goal_pos = it.position_target; m_armed = 1;
         end
         KIND_CLR_TGT: m_armed = 0;
         KIND_RST_POS: m_pos = 0;
         default: ;   // unused kinds leave everything alone
      endcase
      r.step_level = m_level;
      r.position = m_pos;
      r.moving = m_run;
      r.speed_now = m_speed;
      r.alarm_period = m_period;
      r.target_hit = hit;
      r.auto_halt = halt;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------
   logic         typed_pending;
   motor_state_t typed_want;

   task automatic send_cmd(cmd_item_t it);
      motor_state_t p;
      req_chan.valid <= 1'b1;
      req_chan.kind <= it.kind;
      req_chan.now_ms <= it.now_ms;
      req_chan.speed_target <= it.speed_target;
      req_chan.ramp_up_ms <= it.ramp_up_ms;
      req_chan.ramp_down_ms <= it.ramp_down_ms;
      req_chan.position_target <= it.position_target;
      do @(posedge clock); while (!req_chan.ready);
      p = motor_step(it);
      // hand-typed rows must agree with the predictor too
      if (typed_pending && p != typed_want) begin
         $display("%0t predictor vs typed row: expected %p actual %p", $time, typed_want, p);
         n_err++;
      end
      motor_q.push_back(typed_pending ? typed_want : p);
      typed_pending = 0;
   endtask

   int burst_left = 0;

   // bursts of random length separated by random gaps
   task automatic paced_send(cmd_item_t it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 10);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      send_cmd(it);
   endtask

   // idle the sender until every result is back, then let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (motor_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 5'({idx, 2'b00}); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);   // write lands here
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DIR:      m_cfg.dir_fwd = val[0];
         CSR_MIN_RUN:  m_cfg.min_run = val[9:0];
         CSR_IDLE_PER: m_cfg.idle_per = val[23:0];
         CSR_MIN_PER:  m_cfg.min_per = val[15:0];
         CSR_CLK_HZ:   m_cfg.clk_hz = val[26:0];
         default: ;
      endcase
   endtask

   task automatic csr_setup(logic dir, logic [9:0] mr, logic [23:0] ip,
                            logic [15:0] mp, logic [26:0] hz);
      csr_write(CSR_DIR, {31'd0, dir});
      csr_write(CSR_MIN_RUN, {22'd0, mr});
      csr_write(CSR_IDLE_PER, {8'd0, ip});
      csr_write(CSR_MIN_PER, {16'd0, mp});
      csr_write(CSR_CLK_HZ, {5'd0, hz});
   endtask

   function automatic cmd_item_t noise_item();
      cmd_item_t it;
      it.kind = 4'($urandom);
      it.now_ms = $urandom;
      it.speed_target = 20'($urandom);
      it.ramp_up_ms = 16'($urandom);
      it.ramp_down_ms = 16'($urandom);
      it.position_target = $urandom;
      return it;
   endfunction

   function automatic cmd_item_t mk(logic [3:0] k, logic [31:0] now, logic [19:0] spd,
                                    logic [15:0] up, logic [15:0] dn,
                                    logic signed [31:0] tgt);
      cmd_item_t it;
      it = '{kind: k, now_ms: now, speed_target: spd, ramp_up_ms: up,
             ramp_down_ms: dn, position_target: tgt};
      return it;
   endfunction

   // ---------------------------------------------------------------
   // Motion profile generator: mostly start / ramp / step / stop runs
   // ---------------------------------------------------------------
   logic [31:0] wall_ms = 32'd1000;

   function automatic cmd_item_t profile_item();
      cmd_item_t it;
      int        sel;
      it = noise_item();   // unused fields keep random content
      sel = $urandom_range(0, 99);
      if (sel < 5) return it;   // pure noise, odd kinds included
      if (!m_run && sel < 30) begin
         it.kind = ($urandom_range(0, 1) == 0) ? 4'(KIND_SET_SPEED) : 4'(KIND_START);
         if ($urandom_range(0, 9) != 0) begin
            it.speed_target = 20'($urandom_range(0, 3000));
            it.ramp_up_ms = 16'($urandom_range(0, 300));
            it.ramp_down_ms = 16'($urandom_range(0, 300));
         end
      end else if (sel < 60) it.kind = KIND_ALARM;
      else if (sel < 80) begin
         it.kind = KIND_TICK;
         case ($urandom_range(0, 9))
            0: wall_ms = wall_ms;                           // no elapsed time
            1: wall_ms = $urandom;                          // jump, may wrap
            default: wall_ms = wall_ms + $urandom_range(1, 40);
         endcase
         it.now_ms = wall_ms;
      end else if (sel < 86) begin
         it.kind = KIND_SET_TGT;
         it.position_target = $signed(m_pos) + $signed(32'($urandom_range(0, 12)) - 32'sd4);
      end else if (sel < 90) it.kind = KIND_STOP;
      else if (sel < 92) it.kind = KIND_HARD_STOP;
      else if (sel < 95) it.kind = KIND_CLR_TGT;
      else if (sel < 97) it.kind = KIND_RST_POS;
      else it.kind = KIND_SET_SPEED;
      return it;
   endfunction

   // ---------------------------------------------------------------
   // Receiver: stall pattern drawn from four modes and changed on a counter of clock cycles
   // ---------------------------------------------------------------
   int rx_mode = 0, rx_cnt = 0, rx_hold = 0;

   always @(posedge clock) begin
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 64 == 63) rx_mode <= $urandom_range(0, 3);
      if (reset) rsp_chan.ready <= 1'b0;
      else begin
         case (rx_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom);
            2: rsp_chan.ready <= (rx_cnt % 4 == 0);
            default: begin
               if (rx_hold > 0) begin
                  rx_hold <= rx_hold - 1;
                  rsp_chan.ready <= 1'b0;
               end else begin
                  rx_hold <= $urandom_range(0, 40);
                  rsp_chan.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      motor_state_t w, a;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         a.step_level = rsp_chan.step_level;
         a.position = rsp_chan.position;
         a.moving = rsp_chan.moving;
         a.speed_now = rsp_chan.speed_now;
         a.alarm_period = rsp_chan.alarm_period;
         a.target_hit = rsp_chan.target_hit;
         a.auto_halt = rsp_chan.auto_halt;
         if (motor_q.size() == 0) begin
            $display("%0t unexpected result: expected none actual %p", $time, a);
            n_err++;
         end else begin
            w = motor_q.pop_front();
            if (w.step_level !== a.step_level) begin
               $display("%0t step_level: expected %0d actual %0d", $time, w.step_level,
                        a.step_level);
               n_err++;
            end
            if (w.position !== a.position) begin
               $display("%0t position: expected %0d actual %0d", $time, w.position,
                        a.position);
               n_err++;
            end
            if (w.moving !== a.moving) begin
               $display("%0t moving: expected %0d actual %0d", $time, w.moving, a.moving);
               n_err++;
            end
            if (w.speed_now !== a.speed_now) begin
               $display("%0t speed_now: expected %h actual %h", $time, w.speed_now,
                        a.speed_now);
               n_err++;
            end
            if (w.alarm_period !== a.alarm_period) begin
               $display("%0t alarm_period: expected %0d actual %0d", $time, w.alarm_period,
                        a.alarm_period);
               n_err++;
            end
            if (w.target_hit !== a.target_hit) begin
               $display("%0t target_hit: expected %0d actual %0d", $time, w.target_hit,
                        a.target_hit);
               n_err++;
            end
            if (w.auto_halt !== a.auto_halt) begin
               $display("%0t auto_halt: expected %0d actual %0d", $time, w.auto_halt,
                        a.auto_halt);
               n_err++;
            end
         end
      end
   end

   // watchdog: cycles in a row with no item moving on either channel
   int quiet = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == 20000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------
   dir_row_t dir_rows[$];

   task automatic add_row(cmd_item_t it);
      dir_row_t r;
      r.item = it;
      r.typed = 0;
      r.want = '{default: '0};
      dir_rows.push_back(r);
   endtask

   // row whose result is plain from reset: stopped at 0, idle period
   task automatic add_idle_row(cmd_item_t it);
      dir_row_t r;
      r.item = it;
      r.typed = 1;
      r.want = '{step_level: 0, position: 0, moving: 0, speed_now: 0,
                 alarm_period: RST_IDLE_PER, target_hit: 0, auto_halt: 0};
      dir_rows.push_back(r);
   endtask

   initial begin
      cmd_item_t it;
      int        phase, n;

      req_chan.valid = 1'b0;
      req_chan.kind = '0;
      req_chan.now_ms = '0;
      req_chan.speed_target = '0;
      req_chan.ramp_up_ms = '0;
      req_chan.ramp_down_ms = '0;
      req_chan.position_target = '0;
      rsp_chan.ready = 1'b0;
      typed_pending = 0;
      motor_reset();

      // alarm, tick and unused kinds while stopped, zero-speed set speed, clear target
      add_idle_row(mk(KIND_ALARM, 0, 0, 0, 0, 0));
      add_idle_row(mk(KIND_TICK, 5, 0, 0, 0, 0));
      add_idle_row(mk(4'd9, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF));
      add_idle_row(mk(4'd15, 0, 0, 0, 0, 32'sh80000000));
      add_idle_row(mk(KIND_SET_SPEED, 0, 0, 16'hFFFF, 0, 0));
      add_idle_row(mk(KIND_CLR_TGT, 0, 0, 0, 0, 0));
      // ramp up, step to a target, deferred clear on the next tick
      add_row(mk(KIND_SET_SPEED, 0, 1000, 100, 0, 0));
      add_row(mk(KIND_START, 0, 0, 0, 0, 0));
      add_row(mk(KIND_TICK, 5, 0, 0, 0, 0));          // zero elapsed time
      add_row(mk(KIND_TICK, 15, 0, 0, 0, 0));
      add_row(mk(KIND_SET_TGT, 0, 0, 0, 0, 2));
      repeat (4) add_row(mk(KIND_ALARM, 0, 0, 0, 0, 0));
      add_row(mk(KIND_TICK, 20, 0, 0, 0, 0));
      add_row(mk(KIND_RST_POS, 0, 0, 0, 0, 0));
      // widest speed and ramps, tick across the time wrap, stop and halt
      add_row(mk(KIND_SET_SPEED, 0, 20'hFFFFF, 16'hFFFF, 16'd1, 0));
      add_row(mk(KIND_START, 0, 0, 0, 0, 0));
      add_row(mk(KIND_TICK, 32'hFFFFFFF0, 0, 0, 0, 0));
      add_row(mk(KIND_TICK, 32'h00000010, 0, 0, 0, 0));
      add_row(mk(KIND_ALARM, 0, 0, 0, 0, 0));
      add_row(mk(KIND_STOP, 0, 0, 0, 0, 0));
      add_row(mk(KIND_TICK, 32'h00000011, 0, 0, 0, 0));
      add_row(mk(KIND_HARD_STOP, 0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         typed_pending = dir_rows[i].typed;
         typed_want = dir_rows[i].want;
         send_cmd(dir_rows[i].item);
      end

      // random phases, each under a different register setting
      for (phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: csr_setup(1'b0, 10'd0, 24'd0, 16'd0, 27'd1);
            1: csr_setup(1'b1, 10'd1000, 24'hFFFFFF, 16'hFFFF, 27'd100000000);
            2: csr_setup(1'b0, 10'd5, 24'd1, 16'd1, 27'h7FFFFFF);
            3: csr_setup(1'b1, RST_MIN_RUN, RST_IDLE_PER, RST_MIN_PER, RST_CLK_HZ);
            default: csr_setup(1'($urandom), 10'($urandom), 24'($urandom),
                               16'($urandom), 27'($urandom));
         endcase
         n = 290;
         while (n > 0) begin
            it = profile_item();
            if (it.kind > 4'(KIND_RST_POS)) paced_send(it);   // ignored, not counted
            else begin
               paced_send(it);
               n--;
            end
         end
      end

      drain();
      if (n_err == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
design/ssg_pkg.sv
design/ssg_if.sv
design/ssg_arith.sv
design/ssg_ctrl.sv
design/ssg_datapath.sv
design/stepper_ramp_step_generator.sv
tb/tb_top.sv
